[rtl/core/binary_closing_5x5_defines.svh]
// assertion macros for the closing block checker
`ifndef BINARY_CLOSING_5X5_DEFINES_SVH
`define BINARY_CLOSING_5X5_DEFINES_SVH

// same-cycle implication, sampled on clk and disabled in reset
`define CLO_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("closing check failed: implication");

// next-cycle implication, sampled on clk and disabled in reset
`define CLO_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("closing check failed: next cycle");

`endif

[rtl/core/clo_pkg.sv]
`timescale 1ns / 1ps

package clo_pkg;

  // square structuring element edge and the number of stored lines
  localparam int WIN   = 5;
  localparam int LINES = WIN - 1;

  // configuration data width
  localparam int CFG_DW = 10;

  // register indexes of the configuration port
  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  // partial reduction of one window column
  typedef struct packed {
    logic any;
    logic all;
  } cell_stat_t;

endpackage

[rtl/core/clo_cell.sv]
`timescale 1ns / 1ps

module clo_cell (
  input  logic                     clk,
  input  logic                     adv_i,
  input  logic [clo_pkg::WIN-1:0]  col_i,
  input  logic [clo_pkg::WIN-1:0]  row_ok_i,
  input  logic                     col_ok_i,
  output logic [clo_pkg::WIN-1:0]  col_o,
  output clo_pkg::cell_stat_t      stat_o
);
  import clo_pkg::*;

  logic [WIN-1:0] col_r;
  logic [WIN-1:0] hit;

  // column moves one place along the window on every advance
  always_ff @(posedge clk) begin
    if (adv_i) col_r <= col_i;
  end

  assign col_o = col_r;

  // masked column terms: any set pixel inside, or all inside and set
  assign hit        = col_i & row_ok_i;
  assign stat_o.any = col_ok_i & (|hit);
  assign stat_o.all = col_ok_i & (&row_ok_i) & (&col_i);

endmodule

[rtl/core/clo_line_store.sv]
`timescale 1ns / 1ps

module clo_line_store #(
  parameter  int DEPTH = 512,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we_i,
  input  logic [AW-1:0]             wr_addr_i,
  input  logic [AW-1:0]             rd_addr_i,
  input  logic [clo_pkg::LINES-1:0] wdata_i,
  output logic [clo_pkg::LINES-1:0] rdata_o
);
  import clo_pkg::*;

  logic [LINES-1:0] mem [DEPTH];
  logic [LINES-1:0] rd_r;

  // one column of four lines per entry, read ahead for the next column
  always_ff @(posedge clk) begin
    if (we_i) mem[wr_addr_i] <= wdata_i;
    // forward the word being written when the next column is the same one
    if (we_i && (rd_addr_i == wr_addr_i)) rd_r <= wdata_i;
    else rd_r <= mem[rd_addr_i];
  end

  assign rdata_o = rd_r;

endmodule

[rtl/core/clo_stage.sv]
`timescale 1ns / 1ps

module clo_stage #(
  parameter  int MAX_W = 512,
  parameter  int MAX_H = 512,
  parameter  bit ERODE = 1'b0,
  localparam int XW    = $clog2(MAX_W),
  localparam int WB    = $clog2(MAX_W + 1),
  localparam int HB    = $clog2(MAX_H + 1),
  localparam int YW    = $clog2(MAX_H + 8)
) (
  input  logic          clk,
  input  logic          adv_i,
  input  logic          pix_i,
  input  logic [XW-1:0] wr_col_i,
  input  logic [XW-1:0] rd_col_i,
  input  logic [XW-1:0] cx_i,
  input  logic [YW-1:0] cy_i,
  input  logic [WB-1:0] w_i,
  input  logic [HB-1:0] h_i,
  output logic          res_o
);
  import clo_pkg::*;

  logic [LINES-1:0] line_rd;
  logic [WIN-1:0]   cols [WIN];
  logic [WIN-1:0]   row_ok;
  logic [WIN-1:0]   col_ok;
  cell_stat_t       stat [WIN];
  logic [WIN-1:0]   any_v;
  logic [WIN-1:0]   all_v;
  logic [YW:0]      cye;
  logic [YW:0]      he;
  logic [WB:0]      cxe;
  logic [WB:0]      we;

  // four previous lines at the incoming column
  clo_line_store #(.DEPTH(MAX_W)) u_lines (
    .clk       (clk),
    .we_i      (adv_i),
    .wr_addr_i (wr_col_i),
    .rd_addr_i (rd_col_i),
    .wdata_i   ({line_rd[LINES-2:0], pix_i}),
    .rdata_o   (line_rd)
  );

  // newest column: bit 0 is the incoming pixel, bit j is j lines above
  assign cols[0] = {line_rd, pix_i};

  // image bounds around the window center
  assign cye = (YW + 1)'(cy_i);
  assign he  = (YW + 1)'(h_i);
  assign cxe = (WB + 1)'(cx_i);
  assign we  = (WB + 1)'(w_i);

  assign row_ok[0] = (cye + (YW + 1)'(2)) < he;
  assign row_ok[1] = (cye + (YW + 1)'(1)) < he;
  assign row_ok[2] = cye < he;
  assign row_ok[3] = cye >= (YW + 1)'(1);
  assign row_ok[4] = cye >= (YW + 1)'(2);

  assign col_ok[0] = (cxe + (WB + 1)'(2)) < we;
  assign col_ok[1] = (cxe + (WB + 1)'(1)) < we;
  assign col_ok[2] = cxe < we;
  assign col_ok[3] = cxe >= (WB + 1)'(1);
  assign col_ok[4] = cxe >= (WB + 1)'(2);

  // chain of window columns, newest first
  for (genvar k = 0; k < WIN; k++) begin : g_cell
    if (k < WIN - 1) begin : g_mid
      clo_cell u_cell (
        .clk      (clk),
        .adv_i    (adv_i),
        .col_i    (cols[k]),
        .row_ok_i (row_ok),
        .col_ok_i (col_ok[k]),
        .col_o    (cols[k+1]),
        .stat_o   (stat[k])
      );
    end else begin : g_end
      clo_cell u_cell (
        .clk      (clk),
        .adv_i    (adv_i),
        .col_i    (cols[k]),
        .row_ok_i (row_ok),
        .col_ok_i (col_ok[k]),
        .col_o    (),
        .stat_o   (stat[k])
      );
    end
    assign any_v[k] = stat[k].any;
    assign all_v[k] = stat[k].all;
  end

  // dilation takes any pixel, erosion needs every pixel
  assign res_o = ERODE ? (&all_v) : (|any_v);

endmodule

[rtl/core/binary_closing_5x5.sv]
`timescale 1ns / 1ps

// 5x5 binary closing (square dilation then square erosion) of a raster mask
// stream. Pixels outside the image count as 0 in both passes, so the two outer
// rows and columns of the result are 0. One request is taken every clock; the
// result for pixel q leaves with request q + 4*frame_width + 4, so after the
// last pixel of a frame 4*frame_width + 4 flush requests (tuser = 1, or any
// request once the frame's pixels are in) push the tail out. The result with
// tlast high ends the frame. A flush request inside the frame is dropped. The
// only stall is the output register: in_tready drops while a result waits and
// out_tready is low. Each pass holds four lines in a MAX_WIDTH x 4 bit memory
// with one read and one write per clock; line contents outside the current
// frame are never used, so no clearing pass runs after reset. Writing a size
// register restarts the frame.
module binary_closing_5x5 #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [0] pixel_set, [7:1] zero
  input  logic [0:0]                 in_tuser,   // [0] operation
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata,  // [0] closed_pixel, [7:1] zero
  output logic                       out_tlast,  // frame_last
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_addr,
  input  logic [clo_pkg::CFG_DW-1:0] cfg_wdata
);
  import clo_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int WB    = $clog2(MAX_WIDTH + 1);
  localparam int HB    = $clog2(MAX_HEIGHT + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 8);
  localparam int FW    = $clog2(4 * MAX_WIDTH + 5);
  localparam int W_RST = (128 > MAX_WIDTH) ? MAX_WIDTH : 128;
  localparam int H_RST = (128 > MAX_HEIGHT) ? MAX_HEIGHT : 128;

  logic [WB-1:0] w_r, w_nxt;
  logic [HB-1:0] h_r, h_nxt;
  logic [XW-1:0] ix_r, ix_nxt;
  logic [YW-1:0] iy_r, iy_nxt;
  logic [FW-1:0] f_r, f_nxt;
  logic [XW-1:0] c1x_r, c1x_nxt;
  logic [YW-1:0] c1y_r, c1y_nxt;
  logic [XW-1:0] c2x_r, c2x_nxt;
  logic [YW-1:0] c2y_r, c2y_nxt;
  logic          out_valid_r;
  logic          out_pix_r;
  logic          out_last_r;

  logic [31:0]   cfg_val;
  logic [31:0]   cfg_clip;
  logic [FW-1:0] half;
  logic [FW-1:0] delay;
  logic [XW-1:0] col_end;
  logic [YW-1:0] row_end;
  logic          accept;
  logic          in_frame;
  logic          adv;
  logic          s1;
  logic          s2;
  logic          adv2;
  logic          res;
  logic          last;
  logic          dil;
  logic          ero;

  // input handshake: the output register decouples the two sides
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // frame position bookkeeping
  assign half     = (FW'(w_r) << 1) + FW'(2);
  assign delay    = (FW'(w_r) << 2) + FW'(4);
  assign col_end  = XW'(w_r - WB'(1));
  assign row_end  = YW'(h_r) - YW'(1);
  assign in_frame = iy_r < YW'(h_r);
  assign adv      = accept && (!in_frame || !in_tuser[0]);
  assign s1       = f_r >= half;
  assign s2       = f_r >= delay;
  assign adv2     = adv && s1;
  assign res      = adv && s2;
  assign last     = (c2x_r == col_end) && (c2y_r == row_end);

  // size registers, clamped to the supported range
  always_comb begin
    w_nxt    = w_r;
    h_nxt    = h_r;
    cfg_val  = 32'(cfg_wdata);
    cfg_clip = (cfg_val == 32'd0) ? 32'd1 : cfg_val;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_FRAME_WIDTH: begin
          w_nxt = (cfg_clip > MAX_WIDTH) ? WB'(MAX_WIDTH) : cfg_clip[WB-1:0];
        end
        CFG_FRAME_HEIGHT: begin
          h_nxt = (cfg_clip > MAX_HEIGHT) ? HB'(MAX_HEIGHT) : cfg_clip[HB-1:0];
        end
        default: ;
      endcase
    end
  end

  // input, dilation center and erosion center counters
  always_comb begin
    ix_nxt  = ix_r;
    iy_nxt  = iy_r;
    f_nxt   = f_r;
    c1x_nxt = c1x_r;
    c1y_nxt = c1y_r;
    c2x_nxt = c2x_r;
    c2y_nxt = c2y_r;
    if (cfg_we || (res && last)) begin
      ix_nxt  = '0;
      iy_nxt  = '0;
      f_nxt   = '0;
      c1x_nxt = '0;
      c1y_nxt = '0;
      c2x_nxt = '0;
      c2y_nxt = '0;
    end else if (adv) begin
      if (!s2) f_nxt = f_r + FW'(1);
      if (ix_r == col_end) begin
        ix_nxt = '0;
        iy_nxt = iy_r + YW'(1);
      end else begin
        ix_nxt = ix_r + XW'(1);
      end
      if (s1) begin
        if (c1x_r == col_end) begin
          c1x_nxt = '0;
          c1y_nxt = c1y_r + YW'(1);
        end else begin
          c1x_nxt = c1x_r + XW'(1);
        end
      end
      if (s2) begin
        if (c2x_r == col_end) begin
          c2x_nxt = '0;
          c2y_nxt = c2y_r + YW'(1);
        end else begin
          c2x_nxt = c2x_r + XW'(1);
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r         <= WB'(W_RST);
      h_r         <= HB'(H_RST);
      ix_r        <= '0;
      iy_r        <= '0;
      f_r         <= '0;
      c1x_r       <= '0;
      c1y_r       <= '0;
      c2x_r       <= '0;
      c2y_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      w_r   <= w_nxt;
      h_r   <= h_nxt;
      ix_r  <= ix_nxt;
      iy_r  <= iy_nxt;
      f_r   <= f_nxt;
      c1x_r <= c1x_nxt;
      c1y_r <= c1y_nxt;
      c2x_r <= c2x_nxt;
      c2y_r <= c2y_nxt;
      if (res) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res) begin
      out_pix_r  <= ero;
      out_last_r <= last;
    end
  end

  // dilation pass over the raw mask
  clo_stage #(.MAX_W(MAX_WIDTH), .MAX_H(MAX_HEIGHT), .ERODE(1'b0)) u_dilate (
    .clk      (clk),
    .adv_i    (adv),
    .pix_i    (in_tdata[0]),
    .wr_col_i (ix_r),
    .rd_col_i (ix_nxt),
    .cx_i     (c1x_r),
    .cy_i     (c1y_r),
    .w_i      (w_r),
    .h_i      (h_r),
    .res_o    (dil)
  );

  // erosion pass over the dilated mask
  clo_stage #(.MAX_W(MAX_WIDTH), .MAX_H(MAX_HEIGHT), .ERODE(1'b1)) u_erode (
    .clk      (clk),
    .adv_i    (adv2),
    .pix_i    (dil),
    .wr_col_i (c1x_r),
    .rd_col_i (c1x_nxt),
    .cx_i     (c2x_r),
    .cy_i     (c2y_r),
    .w_i      (w_r),
    .h_i      (h_r),
    .res_o    (ero)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_pix_r};
  assign out_tlast  = out_last_r;

endmodule

[rtl/core/clo_checker.sv]
`timescale 1ns / 1ps
`include "binary_closing_5x5_defines.svh"

module clo_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // a stalled result holds its payload
  `CLO_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // a stalled result keeps its frame marker
  `CLO_ASSERT_NXT(a_last_hold, out_tvalid && !out_tready, $stable(out_tlast))

  // an empty output slot never blocks the input side
  `CLO_ASSERT_IMP(a_ready_free, !out_tvalid, in_tready)

  // a new result only follows an accepted request
  `CLO_ASSERT_IMP(a_out_cause, $rose(out_tvalid), $past(in_tvalid && in_tready))

  // padding bits above the result pixel stay zero
  `CLO_ASSERT_IMP(a_out_pad, out_tvalid, out_tdata[7:1] == 7'd0)

endmodule

bind binary_closing_5x5 clo_checker u_clo_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
  import clo_pkg::*;

  localparam int MAX_W  = 512;
  localparam int MAX_H  = 512;
  localparam int RING   = 4 * MAX_W + 8;
  localparam int SETTLE = 16;

  typedef enum bit {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } item_op_t;

  typedef struct packed {
    logic closed;
    logic last;
  } closed_px_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata   = '0;  // [0] pixel_set, [7:1] zero
  logic [0:0]        in_tuser   = '0;  // [0] operation
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;        // [0] closed_pixel, [7:1] zero
  logic              out_tlast;
  logic              cfg_we     = 1'b0;
  logic [0:0]        cfg_addr   = '0;
  logic [CFG_DW-1:0] cfg_wdata  = '0;

  // predictor state: line rings, frame size and request count
  bit raw_ring [RING];
  bit dil_ring [RING];
  int fw     = 128;
  int fh     = 128;
  int in_idx = 0;

  closed_px_t closed_queue [$];

  int send_idle    = 30;
  int recv_idle    = 51;
  int errors       = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int frames_done  = 0;
  int cfg_writes   = 0;

  binary_closing_5x5 #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // random receiver stalls
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  // dilation: any set raw pixel in the 5x5 neighborhood, outside is 0
  function automatic bit dilate_at(int q);
    int y, x, yy, xx;
    y = q / fw;
    x = q % fw;
    for (int dy = -2; dy <= 2; dy++) begin
      yy = y + dy;
      if (yy < 0 || yy >= fh) continue;
      for (int dx = -2; dx <= 2; dx++) begin
        xx = x + dx;
        if (xx < 0 || xx >= fw) continue;
        if (raw_ring[(yy * fw + xx) % RING]) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // erosion: all dilated pixels in the 5x5 neighborhood set, outside is 0
  function automatic bit erode_at(int q);
    int y, x, yy, xx;
    y = q / fw;
    x = q % fw;
    for (int dy = -2; dy <= 2; dy++) begin
      yy = y + dy;
      if (yy < 0 || yy >= fh) return 1'b0;
      for (int dx = -2; dx <= 2; dx++) begin
        xx = x + dx;
        if (xx < 0 || xx >= fw) return 1'b0;
        if (!dil_ring[(yy * fw + xx) % RING]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // closing predictor for one accepted request
  task automatic model_closing(input item_op_t op, input bit pix, output bit dropped);
    int total, half, dly, n, q;
    total   = fw * fh;
    half    = 2 * fw + 2;
    dly     = 4 * fw + 4;
    n       = in_idx;
    dropped = 1'b0;
    // flush inside the frame is dropped
    if (n < total) begin
      if (op == OP_FLUSH) begin
        dropped = 1'b1;
        return;
      end
      raw_ring[n % RING] = pix;
    end
    if (n >= half && n - half < total) dil_ring[(n - half) % RING] = dilate_at(n - half);
    if (n >= dly && n - dly < total) begin
      q = n - dly;
      closed_queue.push_back('{closed: erode_at(q), last: (q == total - 1)});
      in_idx = (q == total - 1) ? 0 : n + 1;
    end else begin
      in_idx = n + 1;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    closed_px_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (closed_queue.size() == 0) begin
        $error("result with no pending request: closed_pixel %0b frame_last %0b",
               out_tdata[0], out_tlast);
        errors++;
      end else begin
        want = closed_queue.pop_front();
        results_seen++;
        if (want.last) frames_done++;
        if (out_tdata[0] !== want.closed) begin
          $error("closed_pixel expected %0b actual %0b", want.closed, out_tdata[0]);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("frame_last expected %0b actual %0b", want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  // one request on the input side, with random sender gaps
  task automatic send_item(input item_op_t op, input bit pix);
    bit dropped;
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'b0, pix};
    do @(posedge clk); while (!in_tready);
    model_closing(op, pix, dropped);
    if (!dropped) items_sent++;
  endtask

  // wait until every pending result is out and the pipeline settles
  task automatic drain_block();
    in_tvalid <= 1'b0;
    while (closed_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // size register write, only once no result is pending
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DW-1:0] val);
    int v, lim;
    drain_block();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    lim = (idx == CFG_FRAME_WIDTH) ? MAX_W : MAX_H;
    v   = int'(val);
    if (v < 1) v = 1;
    if (v > lim) v = lim;
    if (idx == CFG_FRAME_WIDTH) fw = v;
    else fh = v;
    in_idx = 0;
    cfg_writes++;
  endtask

  task automatic set_size(input int w, input int h);
    write_reg(CFG_FRAME_WIDTH, CFG_DW'(w));
    write_reg(CFG_FRAME_HEIGHT, CFG_DW'(h));
  endtask

  // whole frame plus flush tail; noisy adds dropped flushes and tail pixels
  task automatic send_frame(input int density, input bit noisy);
    int total;
    total = fw * fh;
    for (int i = 0; i < total; i++) begin
      if (noisy && $urandom_range(19) == 0) send_item(OP_FLUSH, 1'($urandom_range(1)));
      send_item(OP_PIXEL, $urandom_range(99) < density);
    end
    for (int i = 0; i < 4 * fw + 4; i++) begin
      if (noisy && $urandom_range(3) == 0) send_item(OP_PIXEL, 1'($urandom_range(1)));
      else send_item(OP_FLUSH, 1'($urandom_range(1)));
    end
  endtask

  // a flush inside a frame is dropped; size writes in the middle of a frame restart it
  task automatic test_mid_frame_drop();
    for (int i = 0; i < 20; i++) begin
      if (i == 5) send_item(OP_FLUSH, 1'b1);
      send_item(OP_PIXEL, 1'($urandom_range(1)));
    end
    set_size(6, 6);
    // cut off after the first few results have left
    for (int i = 0; i < 33; i++) send_item(OP_PIXEL, $urandom_range(99) < 60);
    write_reg(CFG_FRAME_HEIGHT, 10'd5);
    send_frame(60, 1'b0);
  endtask

  // out of range sizes, clamped to the supported range
  task automatic test_size_limits();
    write_reg(CFG_FRAME_WIDTH, 10'd0);
    write_reg(CFG_FRAME_HEIGHT, 10'd0);
    send_frame(100, 1'b0);
    // clamped to the largest frame, no result comes this early
    write_reg(CFG_FRAME_WIDTH, 10'h3FF);
    write_reg(CFG_FRAME_HEIGHT, 10'h3FF);
    for (int i = 0; i < 40; i++) send_item(OP_PIXEL, $urandom_range(99) < 50);
  endtask

  // back to back frames, solid and empty, pixels in the tail act as flush
  task automatic test_solid_frames();
    set_size(7, 6);
    send_frame(100, 1'b1);
    send_frame(0, 1'b0);
    send_frame(100, 1'b0);
  endtask

  // random frames in three idling phases
  task automatic test_random_frames();
    int start, w, h, density, cut;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle = 30; recv_idle = 51; end
        1: begin send_idle = 51; recv_idle = 30; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      start = items_sent;
      while (items_sent - start < 40) begin
        if ($urandom_range(1)) begin
          w = ($urandom_range(7) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 10);
          h = ($urandom_range(7) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 9);
          set_size(w, h);
        end
        case ($urandom_range(4))
          0: density = 0;
          1: density = 8;
          2: density = 25;
          3: density = 50;
          default: density = 90;
        endcase
        if ($urandom_range(7) == 0) begin
          // broken frame: stop somewhere and restart it with a size write
          cut = $urandom_range(1, fw * fh + 4 * fw + 3);
          for (int i = 0; i < cut; i++) send_item(OP_PIXEL, $urandom_range(99) < density);
          if ($urandom_range(1)) write_reg(CFG_FRAME_WIDTH, CFG_DW'(fw));
          else write_reg(CFG_FRAME_HEIGHT, CFG_DW'(fh));
        end else begin
          send_frame(density, $urandom_range(3) == 0);
        end
      end
    end
  endtask

  // main sequence
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_mid_frame_drop();
    test_size_limits();
    test_solid_frames();
    test_random_frames();
    in_tvalid <= 1'b0;
    for (int i = 0; i < 100000 && closed_queue.size() != 0; i++) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (closed_queue.size() != 0) begin
      $error("%0d results never arrived", closed_queue.size());
      errors++;
    end
    $display("covered %0d requests and %0d checked results over %0d complete frames",
             items_sent, results_seen, frames_done);
    $display("%0d size writes, 1x1 up to 10x9 frames, out of range sizes, restarts mid frame",
             cfg_writes);
    if (errors == 0) begin
      $display("binary_closing_5x5 verification clean");
    end else begin
      $display("binary_closing_5x5 verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("binary_closing_5x5 verification failed");
    $finish;
  end

endmodule
